[rtl/server_info_reply_bot_count_scrubber_macros.svh]
// Assertion helpers shared by the scrubber RTL.
`ifndef SERVER_INFO_REPLY_BOT_COUNT_SCRUBBER_MACROS_SVH
`define SERVER_INFO_REPLY_BOT_COUNT_SCRUBBER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIRBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sirbc_pkg.sv]
`timescale 1ns / 1ps

package sirbc_pkg;

  // Parser position within a server-info reply.
  typedef enum logic [4:0] {
    ST_H0      = 5'd0,
    ST_H1      = 5'd1,
    ST_H2      = 5'd2,
    ST_H3      = 5'd3,
    ST_TYPE    = 5'd4,
    ST_ADDR    = 5'd5,
    ST_NAME    = 5'd6,
    ST_MAP     = 5'd7,
    ST_FOLDER  = 5'd8,
    ST_GAME    = 5'd9,
    ST_PLAYERS = 5'd10,
    ST_MAXP    = 5'd11,
    ST_PROTO   = 5'd12,
    ST_STYPE   = 5'd13,
    ST_ENV     = 5'd14,
    ST_VIS     = 5'd15,
    ST_MOD     = 5'd16,
    ST_URL     = 5'd17,
    ST_DLURL   = 5'd18,
    ST_NULLB   = 5'd19,
    ST_VER     = 5'd20,
    ST_SIZE    = 5'd21,
    ST_MTYPE   = 5'd22,
    ST_DLL     = 5'd23,
    ST_VAC     = 5'd24,
    ST_BOTS    = 5'd25,
    ST_FAIL    = 5'd26
  } parse_state_t;

  // Byte codes checked by the parser.
  localparam logic [7:0] CH_HDR   = 8'hff;
  localparam logic [7:0] CH_TYPE  = 8'h6d;  // 'm'
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UD    = 8'h44;  // 'D'
  localparam logic [7:0] CH_LD    = 8'h64;  // 'd'
  localparam logic [7:0] CH_UL    = 8'h4c;  // 'L'
  localparam logic [7:0] CH_LL    = 8'h6c;  // 'l'
  localparam logic [7:0] CH_UW    = 8'h57;  // 'W'
  localparam logic [7:0] CH_LW    = 8'h77;  // 'w'
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ONE   = 8'h01;

  // Remaining bytes of a skipped four-byte long after its first byte.
  localparam logic [1:0] SKIP_LONG = 2'd3;

  // Status from the parser to the output stage.
  typedef struct packed {
    logic zero;       // current beat is the bot count and gets replaced
    logic at_header;  // parser waits for the first header byte
  } parse_status_t;

endpackage

[rtl/sirbc_in_if.sv]
`timescale 1ns / 1ps

// Input byte stream.
interface sirbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       last_in;

  modport source (output valid, output data_in, output last_in, input ready);
  modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

[rtl/sirbc_out_if.sv]
`timescale 1ns / 1ps

// Output byte stream.
interface sirbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;
  logic       zeroed;

  modport source (output valid, output data_out, output last_out, output zeroed, input ready);
  modport sink   (input valid, input data_out, input last_out, input zeroed, output ready);
endinterface

[rtl/sirbc_parse.sv]
`timescale 1ns / 1ps
`include "server_info_reply_bot_count_scrubber_macros.svh"

module sirbc_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   enable,
  input  logic                   beat,
  input  logic [7:0]             data,
  input  logic                   last,
  output sirbc_pkg::parse_status_t status
);

  sirbc_pkg::parse_state_t state_r, state_nxt;
  logic       port_seen_r, port_seen_nxt;
  logic       mod_present_r, mod_present_nxt;
  logic [1:0] skip_left_r, skip_left_nxt;
  logic       zero;
  logic       is_flag;
  logic       is_digit;

  assign is_flag  = (data == sirbc_pkg::CH_NUL) || (data == sirbc_pkg::CH_ONE);
  assign is_digit = (data >= sirbc_pkg::CH_DIG0) && (data <= sirbc_pkg::CH_DIG9);

  // Next parse position for the byte on the input.
  always_comb begin
    state_nxt       = state_r;
    port_seen_nxt   = port_seen_r;
    mod_present_nxt = mod_present_r;
    skip_left_nxt   = skip_left_r;
    zero            = 1'b0;
    unique case (state_r)
      sirbc_pkg::ST_H0, sirbc_pkg::ST_H1, sirbc_pkg::ST_H2, sirbc_pkg::ST_H3: begin
        state_nxt = (data == sirbc_pkg::CH_HDR) ?
                    sirbc_pkg::parse_state_t'(state_r + 5'd1) : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_TYPE: begin
        state_nxt = (data == sirbc_pkg::CH_TYPE && enable) ?
                    sirbc_pkg::ST_ADDR : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_ADDR: begin
        if (data == sirbc_pkg::CH_NUL) begin
          state_nxt = port_seen_r ? sirbc_pkg::ST_NAME : sirbc_pkg::ST_FAIL;
        end else if (data == sirbc_pkg::CH_COLON) begin
          if (port_seen_r) begin
            state_nxt = sirbc_pkg::ST_FAIL;
          end else begin
            port_seen_nxt = 1'b1;
          end
        end else if (data == sirbc_pkg::CH_DOT) begin
          if (port_seen_r) begin
            state_nxt = sirbc_pkg::ST_FAIL;
          end
        end else if (!is_digit) begin
          state_nxt = sirbc_pkg::ST_FAIL;
        end
      end
      sirbc_pkg::ST_NAME, sirbc_pkg::ST_MAP, sirbc_pkg::ST_FOLDER, sirbc_pkg::ST_GAME,
      sirbc_pkg::ST_URL, sirbc_pkg::ST_DLURL: begin
        if (data == sirbc_pkg::CH_NUL) begin
          state_nxt = sirbc_pkg::parse_state_t'(state_r + 5'd1);
        end
      end
      sirbc_pkg::ST_PLAYERS, sirbc_pkg::ST_MAXP, sirbc_pkg::ST_PROTO: begin
        state_nxt = sirbc_pkg::parse_state_t'(state_r + 5'd1);
      end
      sirbc_pkg::ST_STYPE: begin
        state_nxt = (data == sirbc_pkg::CH_UD || data == sirbc_pkg::CH_LD ||
                     data == sirbc_pkg::CH_UL || data == sirbc_pkg::CH_LL) ?
                    sirbc_pkg::ST_ENV : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_ENV: begin
        state_nxt = (data == sirbc_pkg::CH_UW || data == sirbc_pkg::CH_LW ||
                     data == sirbc_pkg::CH_UL || data == sirbc_pkg::CH_LL) ?
                    sirbc_pkg::ST_VIS : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_VIS: begin
        state_nxt = is_flag ? sirbc_pkg::ST_MOD : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_MOD: begin
        if (!is_flag) begin
          state_nxt = sirbc_pkg::ST_FAIL;
        end else begin
          mod_present_nxt = data[0];
          state_nxt       = data[0] ? sirbc_pkg::ST_URL : sirbc_pkg::ST_VAC;
        end
      end
      sirbc_pkg::ST_NULLB: begin
        if (data != sirbc_pkg::CH_NUL) begin
          state_nxt = sirbc_pkg::ST_FAIL;
        end else begin
          skip_left_nxt = sirbc_pkg::SKIP_LONG;
          state_nxt     = sirbc_pkg::ST_VER;
        end
      end
      sirbc_pkg::ST_VER, sirbc_pkg::ST_SIZE: begin
        // Each long takes four beats; the count reloads between the two.
        if (skip_left_r != 2'd0) begin
          skip_left_nxt = skip_left_r - 2'd1;
        end else begin
          skip_left_nxt = (state_r == sirbc_pkg::ST_VER) ? sirbc_pkg::SKIP_LONG : 2'd0;
          state_nxt     = sirbc_pkg::parse_state_t'(state_r + 5'd1);
        end
      end
      sirbc_pkg::ST_MTYPE: begin
        state_nxt = is_flag ? sirbc_pkg::ST_DLL : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_DLL: begin
        state_nxt = is_flag ? sirbc_pkg::ST_VAC : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_VAC: begin
        state_nxt = is_flag ? sirbc_pkg::ST_BOTS : sirbc_pkg::ST_FAIL;
      end
      sirbc_pkg::ST_BOTS: begin
        // The bot count is scrubbed only when it closes the packet.
        zero      = last;
        state_nxt = sirbc_pkg::ST_FAIL;
      end
      default: begin
        state_nxt = sirbc_pkg::ST_FAIL;
      end
    endcase
    // The last beat of any packet restarts the parse.
    if (last) begin
      state_nxt       = sirbc_pkg::ST_H0;
      port_seen_nxt   = 1'b0;
      mod_present_nxt = 1'b0;
      skip_left_nxt   = 2'd0;
    end
  end

  // Parse state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sirbc_pkg::ST_H0;
      port_seen_r   <= 1'b0;
      mod_present_r <= 1'b0;
      skip_left_r   <= 2'd0;
    end else if (beat) begin
      state_r       <= state_nxt;
      port_seen_r   <= port_seen_nxt;
      mod_present_r <= mod_present_nxt;
      skip_left_r   <= skip_left_nxt;
    end
  end

  assign status.zero      = zero;
  assign status.at_header = (state_r == sirbc_pkg::ST_H0);

  // A mod section is only walked after the mod flag was set.
  `SIRBC_ASSERT_SAME(a_mod_section, clk, rst_n,
    (state_r == sirbc_pkg::ST_URL || state_r == sirbc_pkg::ST_DLURL ||
     state_r == sirbc_pkg::ST_NULLB || state_r == sirbc_pkg::ST_VER ||
     state_r == sirbc_pkg::ST_SIZE || state_r == sirbc_pkg::ST_MTYPE ||
     state_r == sirbc_pkg::ST_DLL),
    mod_present_r, "mod section without mod flag")
  // The address string cannot end without a port.
  `SIRBC_ASSERT_SAME(a_port_before_name, clk, rst_n, state_r == sirbc_pkg::ST_NAME,
    port_seen_r, "name reached without port")
  // The skip counter runs only inside the two skipped longs.
  `SIRBC_ASSERT_SAME(a_skip_scope, clk, rst_n, skip_left_r != 2'd0,
    (state_r == sirbc_pkg::ST_VER || state_r == sirbc_pkg::ST_SIZE),
    "skip count outside longs")

endmodule

[rtl/server_info_reply_bot_count_scrubber.sv]
`timescale 1ns / 1ps

// Byte-stream filter for server-info replies: every beat on in_ch is forwarded on
// out_ch through a single output register, and a new beat
// is accepted every cycle while out_ch keeps up (one byte per clock sustained).
// When cfg_wdata was written as 1, the packet parser checks each reply and, if it is
// well formed and the bot-count byte is the final beat, forwards that byte as zero
// with zeroed set. The enable is sampled at the type byte of each packet and should
// be written only while the stream is idle.
`include "server_info_reply_bot_count_scrubber_macros.svh"

module server_info_reply_bot_count_scrubber (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  sirbc_in_if.sink           in_ch,
  sirbc_out_if.source        out_ch
);

  logic                      scrub_enable_r;
  logic                      out_valid_r;
  logic [7:0]                data_r;
  logic                      last_r;
  logic                      zeroed_r;
  logic                      beat;
  sirbc_pkg::parse_status_t  status;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scrub_enable_r <= 1'b0;
    end else if (cfg_we) begin
      scrub_enable_r <= cfg_wdata;
    end
  end

  // Accept whenever the output register is empty or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign beat        = in_ch.valid && in_ch.ready;

  sirbc_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .enable (scrub_enable_r),
    .beat   (beat),
    .data   (in_ch.data_in),
    .last   (in_ch.last_in),
    .status (status)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (beat) begin
      data_r   <= status.zero ? 8'd0 : in_ch.data_in;
      last_r   <= in_ch.last_in;
      zeroed_r <= status.zero;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = data_r;
  assign out_ch.last_out = last_r;
  assign out_ch.zeroed   = zeroed_r;

  // A scrubbed beat closes its packet and carries zero.
  `SIRBC_ASSERT_SAME(a_zeroed_last, clk, rst_n, out_valid_r && zeroed_r,
    last_r && (data_r == 8'd0), "zeroed beat not last or not zero")
  // Unscrubbed beats pass through unchanged.
  `SIRBC_ASSERT_NEXT(a_pass_through, clk, rst_n, beat && !status.zero,
    out_valid_r && (data_r == $past(in_ch.data_in)) && !zeroed_r, "byte altered")
  // The parser restarts after every final beat.
  `SIRBC_ASSERT_NEXT(a_restart, clk, rst_n, beat && in_ch.last_in,
    status.at_header && last_r, "parser not restarted")

endmodule
